// ===== rtl/core/bpps_pkg.sv =====
// ----------------------------------------------------------------------------
// Particle step package
// Shared types, command codes and saturation and magnitude helpers for the particle step.
// ----------------------------------------------------------------------------
package bpps_pkg;

	localparam int DATA_W    = 32;
	localparam int TS_W      = 16;
	localparam int LIM_W     = 31;
	localparam int REST_W    = 17;
	localparam int IDX_W     = 3;
	localparam int FRAC_BITS = 16;

	// Controller states.
	typedef enum logic [4:0] {
		S_IDLE, S_AXX, S_AYY, S_FTS, S_SQI, S_SQS, S_FAX, S_FAY, S_RX, S_RY,
		S_GTS, S_GAP, S_DVI, S_DVS, S_VEL, S_VXT, S_VYT, S_WT, S_POS, S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef enum logic [4:0] {
		CMD_NONE, CMD_LOAD, CMD_MUL_AXX, CMD_MUL_AYY, CMD_MUL_FTS, CMD_MUL_FAX,
		CMD_MUL_FAY, CMD_MUL_RX, CMD_MUL_RY, CMD_MUL_GTS, CMD_MUL_VXT,
		CMD_MUL_VYT, CMD_SQRT_INIT, CMD_SQRT_STEP, CMD_DIV_INIT, CMD_DIV_STEP,
		CMD_VEL, CMD_POS, CMD_OUT
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		CFG_X_LIMIT, CFG_Y_LIMIT, CFG_GRAVITY, CFG_FRICTION, CFG_RESTITUTION,
		CFG_START_X, CFG_START_Y
	} cfg_idx_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic vel_zero;
		logic grounded;
	} stat_t;

	// Clamp a wide signed value to the signed 32-bit range.
	function automatic logic [DATA_W-1:0] sat32(input logic signed [35:0] v);
		logic [DATA_W-1:0] r;
		if (v > 36'sh0_7FFF_FFFF) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -36'sh0_8000_0000) begin
			r = 32'h8000_0000;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	// Magnitude of a signed 32-bit value as unsigned 32 bits.
	function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] r;
		r = v[DATA_W-1] ? (~v + 32'd1) : v;
		return r;
	endfunction

endpackage

// ===== rtl/core/bpps_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per step; the quotient is known to fit in 32 bits.
// ----------------------------------------------------------------------------
module bpps_div
	import bpps_pkg::*;
(
	input  logic        clk,
	input  logic        start,
	input  logic        step,
	input  logic [63:0] num,
	input  logic [32:0] den,
	output logic [31:0] quo
);

	logic [32:0] rem_q;
	logic [31:0] nlo_q;
	logic [31:0] quo_q;
	logic [33:0] trial;

	// Bring down the next numerator bit.
	assign trial = {rem_q, nlo_q[31]};

	// Shift, compare and subtract once per step.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num[63:32]};
			nlo_q <= num[31:0];
			quo_q <= '0;
		end else if (step) begin
			nlo_q <= {nlo_q[30:0], 1'b0};
			if (trial >= {1'b0, den}) begin
				rem_q <= 33'(trial - {1'b0, den});
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;

endmodule

// ===== rtl/core/bpps_dp.sv =====
// ----------------------------------------------------------------------------
// Particle step datapath
// Holds configuration and particle state, one shared multiplier, the square
// root iteration and two dividers for the friction direction.
// ----------------------------------------------------------------------------
module bpps_dp
	import bpps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	input  logic [TS_W-1:0]   timestep,
	output logic [DATA_W-1:0] out_pos_x,
	output logic [DATA_W-1:0] out_pos_y,
	output logic [DATA_W-1:0] out_vel_x,
	output logic [DATA_W-1:0] out_vel_y,
	output logic              grounded
);

	localparam logic [LIM_W-1:0]  XLIM_RST = LIM_W'(64'd10 << FRAC_BITS);
	localparam logic [LIM_W-1:0]  YLIM_RST = LIM_W'(64'd10 << FRAC_BITS);
	localparam logic [LIM_W-1:0]  GRAV_RST =
		LIM_W'(((64'd98 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [LIM_W-1:0]  FRIC_RST = LIM_W'(64'd2 << FRAC_BITS);
	localparam logic [REST_W-1:0] REST_RST = 17'd58982;

	// Configuration and particle state.
	logic [LIM_W-1:0]  xlim_q, ylim_q, grav_q, fric_q;
	logic [REST_W-1:0] rest_q;
	logic [DATA_W-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;

	// Per-item working registers.
	logic [TS_W-1:0]   ts_q;
	logic              grounded_q, wall_q, vz_q, vxpos_q, vypos_q;
	logic [31:0]       ax_q, ay_q;
	logic [63:0]       sq_q, numx_q, numy_q;
	logic [LIM_W-1:0]  f_q, g_q;
	logic [32:0]       rbx_q, rby_q;
	logic [31:0]       pdx_q, pdy_q;
	logic [63:0]       n_q, res_q, bit_q;
	logic [63:0]       prod_q;
	cmd_t              op_q;
	logic [DATA_W-1:0] opos_x_q, opos_y_q, ovel_x_q, ovel_y_q;
	logic              ogrounded_q;

	logic [31:0]        mul_a, mul_b;
	logic [31:0]        abs_vx, abs_vy;
	logic [31:0]        quox, quoy;
	logic [63:0]        rb;
	logic               div_start, div_step;
	logic signed [35:0] frx, fry, vxb, vyb, grav_term, dx, dy, pby;
	logic [DATA_W-1:0]  vx_new, vy_new, px_new, py_new;
	logic signed [32:0] floor_y;
	logic               is_ground, is_wall;

	assign abs_vx  = mag32(vel_x_q);
	assign abs_vy  = mag32(vel_y_q);
	assign floor_y = -$signed({2'b00, ylim_q});

	// Start-of-step flags from the state as it stands.
	assign is_ground = $signed({pos_y_q[DATA_W-1], pos_y_q}) < floor_y;
	assign is_wall   = {1'b0, mag32(pos_x_q)} > {2'b00, xlim_q};

	assign stat.vel_zero = vz_q;
	assign stat.grounded = grounded_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd)
			CMD_MUL_AXX: begin mul_a = ax_q; mul_b = ax_q; end
			CMD_MUL_AYY: begin mul_a = ay_q; mul_b = ay_q; end
			CMD_MUL_FTS: begin mul_a = {1'b0, fric_q}; mul_b = {16'd0, ts_q}; end
			CMD_MUL_FAX: begin mul_a = {1'b0, f_q}; mul_b = ax_q; end
			CMD_MUL_FAY: begin mul_a = {1'b0, f_q}; mul_b = ay_q; end
			CMD_MUL_RX:  begin mul_a = ax_q; mul_b = {15'd0, rest_q}; end
			CMD_MUL_RY:  begin mul_a = ay_q; mul_b = {15'd0, rest_q}; end
			CMD_MUL_GTS: begin mul_a = {1'b0, grav_q}; mul_b = {16'd0, ts_q}; end
			CMD_MUL_VXT: begin mul_a = abs_vx; mul_b = {16'd0, ts_q}; end
			CMD_MUL_VYT: begin mul_a = abs_vy; mul_b = {16'd0, ts_q}; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// Multiplier with registered product; the result is written back next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= CMD_NONE;
		end else begin
			case (cmd)
				CMD_MUL_AXX, CMD_MUL_AYY, CMD_MUL_FTS, CMD_MUL_FAX, CMD_MUL_FAY,
				CMD_MUL_RX, CMD_MUL_RY, CMD_MUL_GTS, CMD_MUL_VXT, CMD_MUL_VYT:
					op_q <= cmd;
				default: op_q <= CMD_NONE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	// Product writeback. A restitution gain above one can push the scaled
	// speed past 32 bits, so the bounce products keep 33 bits.
	always_ff @(posedge clk) begin
		case (op_q)
			CMD_MUL_AXX: sq_q   <= prod_q;
			CMD_MUL_AYY: sq_q   <= sq_q + prod_q;
			CMD_MUL_FTS: f_q    <= prod_q[46:16];
			CMD_MUL_FAX: numx_q <= prod_q;
			CMD_MUL_FAY: numy_q <= prod_q;
			CMD_MUL_RX:  rbx_q  <= prod_q[48:16];
			CMD_MUL_RY:  rby_q  <= prod_q[48:16];
			CMD_MUL_GTS: g_q    <= prod_q[46:16];
			CMD_MUL_VXT: pdx_q  <= prod_q[47:16];
			CMD_MUL_VYT: pdy_q  <= prod_q[47:16];
			default: ;
		endcase
	end

	// Item load: latch the timestep, the speed magnitudes and the start-of-step flags.
	always_ff @(posedge clk) begin
		if (cmd == CMD_LOAD) begin
			ts_q       <= timestep;
			grounded_q <= is_ground;
			wall_q     <= is_wall;
			ax_q       <= abs_vx;
			ay_q       <= abs_vy;
			vz_q       <= (vel_x_q == '0) && (vel_y_q == '0);
			vxpos_q    <= !vel_x_q[DATA_W-1] && (vel_x_q != '0);
			vypos_q    <= !vel_y_q[DATA_W-1] && (vel_y_q != '0);
		end
	end

	// Square root of the squared speed, one result bit per step.
	assign rb = res_q + bit_q;

	always_ff @(posedge clk) begin
		if (cmd == CMD_SQRT_INIT) begin
			n_q   <= sq_q;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (cmd == CMD_SQRT_STEP) begin
			bit_q <= bit_q >> 2;
			if (n_q >= rb) begin
				n_q   <= n_q - rb;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	// Friction components: friction magnitude times |v_i| over the speed.
	assign div_start = (cmd == CMD_DIV_INIT);
	assign div_step  = (cmd == CMD_DIV_STEP);

	bpps_div u_div_x (
		.clk   (clk),
		.start (div_start),
		.step  (div_step),
		.num   (numx_q),
		.den   (res_q[32:0]),
		.quo   (quox)
	);

	bpps_div u_div_y (
		.clk   (clk),
		.start (div_start),
		.step  (div_step),
		.num   (numy_q),
		.den   (res_q[32:0]),
		.quo   (quoy)
	);

	// Velocity update: bounce, then gravity and friction.
	always_comb begin
		frx = vz_q ? 36'sd0 : (vxpos_q ? -$signed({4'd0, quox}) : $signed({4'd0, quox}));
		fry = vz_q ? 36'sd0 : (vypos_q ? -$signed({4'd0, quoy}) : $signed({4'd0, quoy}));
		if (wall_q) begin
			vxb = $signed({4'd0, sat32(vel_x_q[DATA_W-1] ? $signed({3'd0, rbx_q})
				: -$signed({3'd0, rbx_q}))});
			vxb = $signed({{4{vxb[31]}}, vxb[31:0]});
		end else begin
			vxb = $signed({{4{vel_x_q[DATA_W-1]}}, vel_x_q});
		end
		if (grounded_q) begin
			vyb = $signed({4'd0, sat32(vel_y_q[DATA_W-1] ? $signed({3'd0, rby_q})
				: -$signed({3'd0, rby_q}))});
			vyb = $signed({{4{vyb[31]}}, vyb[31:0]});
		end else begin
			vyb = $signed({{4{vel_y_q[DATA_W-1]}}, vel_y_q});
		end
		grav_term = grounded_q ? 36'sd0 : $signed({5'd0, g_q});
		vx_new = sat32(vxb + frx);
		vy_new = sat32(vyb - grav_term + fry);
	end

	// Position update from velocity times timestep.
	always_comb begin
		dx  = vel_x_q[DATA_W-1] ? -$signed({4'd0, pdx_q}) : $signed({4'd0, pdx_q});
		dy  = vel_y_q[DATA_W-1] ? -$signed({4'd0, pdy_q}) : $signed({4'd0, pdy_q});
		pby = grounded_q ? $signed({{3{floor_y[32]}}, floor_y})
			: $signed({{4{pos_y_q[DATA_W-1]}}, pos_y_q});
		px_new = sat32($signed({{4{pos_x_q[DATA_W-1]}}, pos_x_q}) + dx);
		py_new = sat32(pby + dy);
	end

	// Configuration and particle state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xlim_q  <= XLIM_RST;
			ylim_q  <= YLIM_RST;
			grav_q  <= GRAV_RST;
			fric_q  <= FRIC_RST;
			rest_q  <= REST_RST;
			pos_x_q <= '0;
			pos_y_q <= '0;
			vel_x_q <= '0;
			vel_y_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_X_LIMIT:     xlim_q  <= cfg_data[LIM_W-1:0];
					CFG_Y_LIMIT:     ylim_q  <= cfg_data[LIM_W-1:0];
					CFG_GRAVITY:     grav_q  <= cfg_data[LIM_W-1:0];
					CFG_FRICTION:    fric_q  <= cfg_data[LIM_W-1:0];
					CFG_RESTITUTION: rest_q  <= cfg_data[REST_W-1:0];
					CFG_START_X:     pos_x_q <= cfg_data;
					CFG_START_Y:     pos_y_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd == CMD_VEL) begin
				vel_x_q <= vx_new;
				vel_y_q <= vy_new;
			end
			if (cmd == CMD_POS) begin
				pos_x_q <= px_new;
				pos_y_q <= py_new;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd == CMD_OUT) begin
			opos_x_q    <= pos_x_q;
			opos_y_q    <= pos_y_q;
			ovel_x_q    <= vel_x_q;
			ovel_y_q    <= vel_y_q;
			ogrounded_q <= grounded_q;
		end
	end

	assign out_pos_x = opos_x_q;
	assign out_pos_y = opos_y_q;
	assign out_vel_x = ovel_x_q;
	assign out_vel_y = ovel_y_q;
	assign grounded  = ogrounded_q;

endmodule

// ===== rtl/core/bpps_ctrl.sv =====
// ----------------------------------------------------------------------------
// Particle step controller
// Sequences the datapath through one step and owns the handshakes.
// ----------------------------------------------------------------------------
module bpps_ctrl
	import bpps_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       out_valid_q;

	// State, step counter and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd == CMD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = CMD_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd     = CMD_LOAD;
					state_d = S_AXX;
				end
			end
			S_AXX: begin cmd = CMD_MUL_AXX; state_d = S_AYY; end
			S_AYY: begin cmd = CMD_MUL_AYY; state_d = S_FTS; end
			S_FTS: begin cmd = CMD_MUL_FTS; state_d = S_SQI; end
			S_SQI: begin
				cmd     = CMD_SQRT_INIT;
				cnt_d   = '0;
				state_d = stat.vel_zero ? S_FAX : S_SQS;
			end
			S_SQS: begin
				cmd   = CMD_SQRT_STEP;
				cnt_d = cnt_q + 5'd1;
				if (&cnt_q) begin
					state_d = S_FAX;
				end
			end
			S_FAX: begin cmd = CMD_MUL_FAX; state_d = S_FAY; end
			S_FAY: begin cmd = CMD_MUL_FAY; state_d = S_RX; end
			S_RX:  begin cmd = CMD_MUL_RX; state_d = S_RY; end
			S_RY:  begin cmd = CMD_MUL_RY; state_d = S_GTS; end
			S_GTS: begin
				cmd     = CMD_MUL_GTS;
				state_d = stat.vel_zero ? S_GAP : S_DVI;
			end
			S_GAP: begin state_d = S_VEL; end
			S_DVI: begin
				cmd     = CMD_DIV_INIT;
				cnt_d   = '0;
				state_d = S_DVS;
			end
			S_DVS: begin
				cmd   = CMD_DIV_STEP;
				cnt_d = cnt_q + 5'd1;
				if (&cnt_q) begin
					state_d = S_VEL;
				end
			end
			S_VEL: begin cmd = CMD_VEL; state_d = S_VXT; end
			S_VXT: begin cmd = CMD_MUL_VXT; state_d = S_VYT; end
			S_VYT: begin cmd = CMD_MUL_VYT; state_d = S_WT; end
			S_WT:  begin state_d = S_POS; end
			S_POS: begin cmd = CMD_POS; state_d = S_OUT; end
			S_OUT: begin
				// Hand the item over once the output register is free.
				if (!out_valid_q || !out_stall) begin
					cmd     = CMD_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin state_d = S_IDLE; end
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/bounded_particle_physics_step_core.sv =====
// The 32-step square root and the 32-step friction dividers run only when the
// velocity is nonzero and are skipped at rest. Items are taken one at a time; the
// next item is taken once the last has reached the output register, even while
// that finished result still waits there.
// Reset: asynchronous, active low; the controller, configuration and particle state
// return to their defaults, with the particle at position zero and zero velocity.
// ----------------------------------------------------------------------------
// Bounded particle step core
// Semi-implicit Euler particle update with wall and floor bounce and friction.
// ----------------------------------------------------------------------------
module bounded_particle_physics_step_core
	import bpps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [TS_W-1:0]   timestep,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] out_pos_x,
	output logic [DATA_W-1:0] out_pos_y,
	output logic [DATA_W-1:0] out_vel_x,
	output logic [DATA_W-1:0] out_vel_y,
	output logic              grounded,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	bpps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	bpps_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.timestep  (timestep),
		.out_pos_x (out_pos_x),
		.out_pos_y (out_pos_y),
		.out_vel_x (out_vel_x),
		.out_vel_y (out_vel_y),
		.grounded  (grounded)
	);

`ifndef SYNTH
	// An accepted item keeps the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block not busy after accepting an item");

	// A load command only comes with an accepted item.
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_LOAD) |-> (in_valid && !in_stall))
		else $error("load without an accepted item");

	// A result never overwrites one that is still held by a stall.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_OUT) |-> !(out_valid && out_stall))
		else $error("pending result overwritten");
`endif

endmodule
